FILE: rtl/core/stae_pkg.sv
// Shared types, register codes, reset values and sine table builder for the tone generator.
`timescale 1ns / 1ps
package stae_pkg;

  localparam int unsigned MAG_W = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [31:0] RST_PHASE_STEP = 32'd42852281;
  localparam logic [31:0] RST_ATTACK = 32'd44100;
  localparam logic [31:0] RST_RELEASE = 32'd44100;
  localparam logic [31:0] RST_NOTE = 32'd264600;
  localparam logic [MAG_W-1:0] RST_PEAK = 15'd16380;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    REG_PHASE_STEP = 3'd0,
    REG_ATTACK     = 3'd1,
    REG_RELEASE    = 3'd2,
    REG_NOTE       = 3'd3,
    REG_PEAK       = 3'd4
  } reg_idx_e;

  // shift-subtract quotient of a series term by a small factorial step
  function automatic logic [63:0] taylor_div(input logic [63:0] num, input logic [7:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= 64'(den)) begin
        rem = rem - 64'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] sum;
    x = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (tbits + 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int i = 1; i <= 7; i++) begin
      term = taylor_div((term * x2) >> 30, 8'((2 * i) * (2 * i + 1)));
      if ((i & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/core/stae_if.sv
// Valid/ready channel interfaces for the restart word and the sample word.
`timescale 1ns / 1ps
interface stae_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stae_out_if;
  logic              valid;
  logic              ready;
  stae_pkg::sample_t sample;
  logic              last_of_note;
  logic              note_done;

  modport source (output valid, output sample, output last_of_note, output note_done,
                  input ready);
  modport sink (input valid, input sample, input last_of_note, input note_done,
                output ready);
endinterface

FILE: rtl/core/sine_tone_with_ar_envelope.sv
// Sine tone generator with linear attack/release envelope, bit-serial envelope arithmetic.
// Words are accepted only in idle, so one word is processed at a time; an attack or release
// word passes through the shared bit-serial shift-add multiplier, the restoring divider and
// the multiplier again, a sustain word through the multiplier only, one bit per cycle over
// 15 bits each pass, and a word after the note has ended goes straight to output.
// Reset: rst_ni clears index, phase and done flag, loads default tone settings.
`timescale 1ns / 1ps
module sine_tone_with_ar_envelope #(
  parameter int unsigned SINE_TABLE_BITS = 8,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stae_in_if.sink           in_i,
  stae_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned MW = stae_pkg::MAG_W;
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned HW = (CB + 1 > MW + 1) ? CB + 1 : MW + 1;
  localparam int unsigned TB = SINE_TABLE_BITS;
  localparam int unsigned DEPTH = 2 ** TB;
  localparam logic [3:0] LAST_STEP = 4'(MW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL1,
    S_DIV,
    S_MUL2,
    S_EMIT
  } state_e;

  state_e state_q;

  logic [31:0]    phase_step_q;
  logic [CB-1:0]  attack_q;
  logic [CB-1:0]  release_q;
  logic [CB-1:0]  note_q;
  logic [MW-1:0]  peak_q;

  logic [CB:0]    idx_q;
  logic [31:0]    phase_q;
  logic           fin_q;
  logic [3:0]     bit_cnt_q;
  logic [HW-1:0]  acc_hi_q;
  logic [MW-1:0]  acc_lo_q;
  logic [HW-2:0]  mcand_q;
  logic [CB-1:0]  den_q;
  logic [MW-1:0]  sine_mag_q;
  logic           sine_neg_q;
  logic           last_q;
  stae_pkg::sample_t res_sample_q;
  logic           res_last_q;
  logic           res_done_q;
  logic           out_valid_q;
  stae_pkg::sample_t out_sample_q;
  logic           out_last_q;
  logic           out_done_q;

  logic [MW-1:0]  sine_rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign sine_rom[k] = stae_pkg::sine_entry(k, SINE_TABLE_BITS);
  end

  // ---------------- configuration port ----------------
  logic             wr_en;
  stae_pkg::reg_idx_e reg_idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = stae_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= stae_pkg::RST_PHASE_STEP;
      attack_q <= CB'(stae_pkg::RST_ATTACK);
      release_q <= CB'(stae_pkg::RST_RELEASE);
      note_q <= CB'(stae_pkg::RST_NOTE);
      peak_q <= stae_pkg::RST_PEAK;
    end else if (wr_en) begin
      unique case (reg_idx)
        stae_pkg::REG_PHASE_STEP: phase_step_q <= pwdata;
        stae_pkg::REG_ATTACK:     attack_q <= pwdata[CB-1:0];
        stae_pkg::REG_RELEASE:    release_q <= pwdata[CB-1:0];
        stae_pkg::REG_NOTE:       note_q <= pwdata[CB-1:0];
        stae_pkg::REG_PEAK:       peak_q <= pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      stae_pkg::REG_PHASE_STEP: prdata = phase_step_q;
      stae_pkg::REG_ATTACK:     prdata = 32'(attack_q);
      stae_pkg::REG_RELEASE:    prdata = 32'(release_q);
      stae_pkg::REG_NOTE:       prdata = 32'(note_q);
      stae_pkg::REG_PEAK:       prdata = 32'(peak_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- decision and serial datapath ----------------
  logic            in_acc;
  logic            over_note;
  logic            in_attack;
  logic            in_release;
  logic            is_last;
  logic [CB+1:0]   rel_sum;
  logic [CB-1:0]   rel_num;
  logic [TB-1:0]   tbl_idx;
  logic [HW:0]     mul_add;
  logic [HW:0]     mul_sum;
  logic [CB:0]     div_t;
  logic            div_ge;
  logic [CB:0]     div_r;
  logic [stae_pkg::SAMPLE_W-1:0] mag_ext;
  logic            out_take;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;

  assign over_note = idx_q > {1'b0, note_q};
  assign in_attack = idx_q < {1'b0, attack_q};
  assign rel_sum = (CB + 2)'(idx_q) + (CB + 2)'(release_q);
  assign in_release = rel_sum > (CB + 2)'(note_q);
  assign is_last = idx_q == {1'b0, note_q};
  assign rel_num = note_q - idx_q[CB-1:0];
  assign tbl_idx = phase_q[29 -: TB] ^ {TB{phase_q[30]}};

  assign mul_add = acc_lo_q[0] ? {2'b00, mcand_q} : '0;
  assign mul_sum = {1'b0, acc_hi_q} + mul_add;

  assign div_t = {acc_hi_q[CB-1:0], acc_lo_q[MW-1]};
  assign div_ge = div_t >= {1'b0, den_q};
  assign div_r = div_ge ? (div_t - {1'b0, den_q}) : div_t;

  assign mag_ext = {1'b0, mul_sum[MW:1]};
  assign out_take = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      phase_q <= '0;
      fin_q <= 1'b0;
      bit_cnt_q <= '0;
      acc_hi_q <= '0;
      acc_lo_q <= '0;
      mcand_q <= '0;
      den_q <= '0;
      sine_mag_q <= '0;
      sine_neg_q <= 1'b0;
      last_q <= 1'b0;
      res_sample_q <= '0;
      res_last_q <= 1'b0;
      res_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_sample_q <= '0;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end else begin
      if (out_take && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.restart) begin
              idx_q <= '0;
              phase_q <= '0;
              fin_q <= 1'b0;
            end
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          bit_cnt_q <= '0;
          if (fin_q || over_note) begin
            fin_q <= 1'b1;
            res_sample_q <= '0;
            res_last_q <= 1'b0;
            res_done_q <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            sine_mag_q <= sine_rom[tbl_idx];
            sine_neg_q <= phase_q[31];
            phase_q <= phase_q + phase_step_q;
            last_q <= is_last;
            if (is_last) begin
              fin_q <= 1'b1;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
            acc_hi_q <= '0;
            acc_lo_q <= peak_q;
            priority if (in_attack) begin
              mcand_q <= (HW - 1)'(idx_q[CB-1:0]);
              den_q <= attack_q;
              state_q <= S_MUL1;
            end else if (in_release) begin
              mcand_q <= (HW - 1)'(rel_num);
              den_q <= release_q;
              state_q <= S_MUL1;
            end else begin
              mcand_q <= (HW - 1)'(sine_rom[tbl_idx]);
              state_q <= S_MUL2;
            end
          end
        end
        S_MUL1: begin
          acc_hi_q <= mul_sum[HW:1];
          acc_lo_q <= {mul_sum[0], acc_lo_q[MW-1:1]};
          if (bit_cnt_q == LAST_STEP) begin
            bit_cnt_q <= '0;
            state_q <= S_DIV;
          end else begin
            bit_cnt_q <= bit_cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          acc_lo_q <= {acc_lo_q[MW-2:0], div_ge};
          if (bit_cnt_q == LAST_STEP) begin
            bit_cnt_q <= '0;
            acc_hi_q <= '0;
            mcand_q <= (HW - 1)'(sine_mag_q);
            state_q <= S_MUL2;
          end else begin
            bit_cnt_q <= bit_cnt_q + 1'b1;
            acc_hi_q <= HW'(div_r[CB-1:0]);
          end
        end
        S_MUL2: begin
          acc_hi_q <= mul_sum[HW:1];
          acc_lo_q <= {mul_sum[0], acc_lo_q[MW-1:1]};
          if (bit_cnt_q == LAST_STEP) begin
            bit_cnt_q <= '0;
            res_sample_q <= sine_neg_q ? stae_pkg::sample_t'(16'd0 - mag_ext)
                                       : stae_pkg::sample_t'(mag_ext);
            res_last_q <= last_q;
            res_done_q <= 1'b0;
            state_q <= S_EMIT;
          end else begin
            bit_cnt_q <= bit_cnt_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_sample_q <= res_sample_q;
            out_last_q <= res_last_q;
            out_done_q <= res_done_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign out_o.last_of_note = out_last_q;
  assign out_o.note_done = out_done_q;

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.note_done |-> out_o.sample == '0 && !out_o.last_of_note)
    else $error("ended note word carries sound");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> acc_hi_q < HW'(den_q))
    else $error("divider remainder not below divisor");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE && !fin_q && is_last |=> fin_q)
    else $error("note not closed after final sample");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE || state_q == S_EMIT |-> bit_cnt_q == '0)
    else $error("bit counter left running");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the sine tone generator: directed notes, then random notes.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned TBL_BITS = 8;
  localparam int unsigned CNT_BITS = 24;
  localparam int unsigned MAG_W = stae_pkg::MAG_W;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned CALM_ITEMS = 150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    stae_pkg::sample_t sample;
    logic              last_of_note;
    logic              note_done;
  } tone_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stae_in_if  in_if ();
  stae_out_if out_if ();

  sine_tone_with_ar_envelope #(
    .SINE_TABLE_BITS(TBL_BITS),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Register mirror and tone state
  logic [31:0]         cfg_step = stae_pkg::RST_PHASE_STEP;
  logic [CNT_BITS-1:0] cfg_attack = stae_pkg::RST_ATTACK[CNT_BITS-1:0];
  logic [CNT_BITS-1:0] cfg_release = stae_pkg::RST_RELEASE[CNT_BITS-1:0];
  logic [CNT_BITS-1:0] cfg_note = stae_pkg::RST_NOTE[CNT_BITS-1:0];
  logic [MAG_W-1:0]    cfg_peak = stae_pkg::RST_PEAK;
  logic [CNT_BITS:0]   tone_idx = '0;
  logic [31:0]         tone_phase = '0;
  logic                tone_over = 1'b0;

  logic [MAG_W-1:0] sine_rom [2**TBL_BITS];
  tone_word_t       expected_words [$];
  int unsigned      mismatches = 0;
  int unsigned      random_sent = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      stall_left = 0;
  bit               calm = 1'b0;

  always #4 clk_i = ~clk_i;

  function automatic logic [MAG_W-1:0] taylor_sine_point(int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] part;
    logic [63:0] rounded;
    longint      acc;
    ang = ((64'(k) * 64'd2 + 64'd1) * stae_pkg::HALF_PI_Q30) >> (TBL_BITS + 1);
    ang_sq = (ang * ang) >> 30;
    part = ang;
    acc = longint'(ang);
    for (int j = 1; j <= 7; j++) begin
      part = ((part * ang_sq) >> 30) / 64'((2 * j) * (2 * j + 1));
      if (j % 2 == 1) begin
        acc = acc - longint'(part);
      end else begin
        acc = acc + longint'(part);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (rounded > 64'd32767) begin
      rounded = 64'd32767;
    end
    return rounded[MAG_W-1:0];
  endfunction

  function automatic tone_word_t predict_tone(bit restart);
    tone_word_t          w;
    logic [63:0]         env;
    logic [63:0]         mag;
    logic [1:0]          quad;
    logic [TBL_BITS-1:0] slot;
    if (restart) begin
      tone_idx = '0;
      tone_phase = '0;
      tone_over = 1'b0;
    end
    if (!tone_over && 64'(tone_idx) > 64'(cfg_note)) begin
      tone_over = 1'b1;
    end
    w.sample = '0;
    w.last_of_note = 1'b0;
    w.note_done = 1'b1;
    if (!tone_over) begin
      if (64'(tone_idx) < 64'(cfg_attack)) begin
        env = (64'(cfg_peak) * 64'(tone_idx)) / 64'(cfg_attack);
      end else if (64'(tone_idx) + 64'(cfg_release) > 64'(cfg_note)) begin
        env = (64'(cfg_peak) * (64'(cfg_note) - 64'(tone_idx))) / 64'(cfg_release);
      end else begin
        env = 64'(cfg_peak);
      end
      quad = tone_phase[31:30];
      slot = tone_phase[29 -: TBL_BITS];
      if (quad[0]) begin
        slot = ~slot;
      end
      mag = (env * 64'(sine_rom[slot])) >> 15;
      w.sample = quad[1] ? stae_pkg::sample_t'(16'(64'd0 - mag))
                         : stae_pkg::sample_t'(mag[15:0]);
      w.last_of_note = (64'(tone_idx) == 64'(cfg_note));
      w.note_done = 1'b0;
      tone_phase = tone_phase + cfg_step;
      if (w.last_of_note) begin
        tone_over = 1'b1;
      end else begin
        tone_idx = tone_idx + 1'b1;
      end
    end
    return w;
  endfunction

  task automatic write_reg(stae_pkg::reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      stae_pkg::REG_PHASE_STEP: cfg_step = value;
      stae_pkg::REG_ATTACK:     cfg_attack = value[CNT_BITS-1:0];
      stae_pkg::REG_RELEASE:    cfg_release = value[CNT_BITS-1:0];
      stae_pkg::REG_NOTE:       cfg_note = value[CNT_BITS-1:0];
      stae_pkg::REG_PEAK:       cfg_peak = value[MAG_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(bit restart);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    expected_words.push_back(predict_tone(restart));
  endtask

  // drop valid and wait for every outstanding sample word
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_count(int unsigned typical);
    case ($urandom_range(0, 9))
      0: return 32'h00FF_FFFF;
      1: return $urandom();
      2: return 32'd0;
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  function automatic logic [31:0] pick_peak();
    logic [31:0] junk;
    junk = $urandom() & 32'hFFFF_8000;
    case ($urandom_range(0, 5))
      0: return junk;
      1: return junk | 32'h0000_7FFF;
      default: return junk | 32'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h4000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    settle();
  endtask

  task automatic test_short_note();
    write_reg(stae_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_reg(stae_pkg::REG_ATTACK, 32'd2);
    write_reg(stae_pkg::REG_RELEASE, 32'd2);
    write_reg(stae_pkg::REG_NOTE, 32'd6);
    write_reg(stae_pkg::REG_PEAK, 32'hFFFF_FFFF);
    send_word(1'b1);
    repeat (8) send_word(1'b0);
    settle();
  endtask

  task automatic test_zero_ramps();
    write_reg(stae_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(stae_pkg::REG_ATTACK, 32'd0);
    write_reg(stae_pkg::REG_RELEASE, 32'd0);
    write_reg(stae_pkg::REG_NOTE, 32'd2);
    write_reg(stae_pkg::REG_PEAK, 32'd16384);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    settle();
  endtask

  task automatic test_single_sample_note();
    write_reg(stae_pkg::REG_NOTE, 32'd0);
    write_reg(stae_pkg::REG_PEAK, 32'd32767);
    send_word(1'b1);
    send_word(1'b0);
    settle();
  endtask

  task automatic test_shortened_note();
    write_reg(stae_pkg::REG_PHASE_STEP, 32'h1234_5679);
    write_reg(stae_pkg::REG_ATTACK, 32'hFFFF_FFFF);
    write_reg(stae_pkg::REG_RELEASE, 32'hFFFF_FFFF);
    write_reg(stae_pkg::REG_NOTE, 32'hFFFF_FFFF);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    settle();
    write_reg(stae_pkg::REG_NOTE, 32'd1);
    send_word(1'b0);
    send_word(1'b1);
    settle();
  endtask

  task automatic test_random_notes();
    int unsigned count;
    int unsigned ramp_max;
    bit          restart;
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(stae_pkg::REG_NOTE, pick_count(40));
      ramp_max = (cfg_note > 40) ? 44 : 32'(cfg_note) + 4;
      if ($urandom_range(0, 3) != 0) write_reg(stae_pkg::REG_ATTACK, pick_count(ramp_max));
      if ($urandom_range(0, 3) != 0) write_reg(stae_pkg::REG_RELEASE, pick_count(ramp_max));
      if ($urandom_range(0, 3) != 0) write_reg(stae_pkg::REG_PEAK, pick_peak());
      if ($urandom_range(0, 3) != 0) write_reg(stae_pkg::REG_PHASE_STEP, pick_step());
      count = ((cfg_note < 60) ? 32'(cfg_note) + 1 : 60) + $urandom_range(0, 3);
      if (count > RANDOM_ITEMS - random_sent) begin
        count = RANDOM_ITEMS - random_sent;
      end
      for (int unsigned i = 0; i < count; i++) begin
        restart = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0);
        send_word(restart);
        random_sent++;
      end
    end
  endtask

  // sink side stalls in bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tone_word_t want;
    tone_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.sample = out_if.sample;
      got.last_of_note = out_if.last_of_note;
      got.note_done = out_if.note_done;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected sample word: sample %0d last %b done %b",
                   got.sample, got.last_of_note, got.note_done);
        end
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample word mismatch: expected sample %0d last %b done %b, got %0d %b %b",
                     want.sample, want.last_of_note, want.note_done,
                     got.sample, got.last_of_note, got.note_done);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int k = 0; k < 2**TBL_BITS; k++) begin
      sine_rom[k] = taylor_sine_point(k);
    end
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.restart <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_short_note();
    test_zero_ramps();
    test_single_sample_note();
    test_shortened_note();
    test_random_notes();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
